[rtl/kbt_pkg.sv]
// Shared types, sizes and constants for the keyed block transposition block.
// No dependencies; every rtl file imports this package.
`timescale 1ns / 1ps

package kbt_pkg;

    localparam int MAX_KEY_LENGTH = 10;
    localparam int KEY_SLOTS      = 10;
    localparam int ROW_LIMIT      = (MAX_KEY_LENGTH < KEY_SLOTS) ? MAX_KEY_LENGTH : KEY_SLOTS;
    localparam int IDX_W          = $clog2(ROW_LIMIT);
    localparam int CNT_W          = $clog2(ROW_LIMIT + 1);
    localparam int CHAR_W         = 8;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;

    localparam logic [CHAR_W-1:0] PAD_CHAR = 8'h71;   // 'q'

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LENGTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIRECTION  = 3'd3;

    localparam logic DIR_ENCRYPT = 1'b0;
    localparam logic DIR_DECRYPT = 1'b1;

    typedef logic [CHAR_W-1:0] char_t;
    typedef logic [IDX_W-1:0]  idx_t;
    typedef logic [CNT_W-1:0]  cnt_t;
    typedef char_t [ROW_LIMIT-1:0] row_t;
    typedef idx_t  [ROW_LIMIT-1:0] sel_t;
    typedef char_t [KEY_SLOTS-1:0] key_t;

    // A finished row passed from the fill stage to the emit buffer
    typedef struct packed {
        logic valid;
        logic last;
        logic empty;
        cnt_t len;
        row_t data;
    } handoff_t;

endpackage

[rtl/kbt_rank.sv]
// Key rank table: registers the stable rank of each key character and
// derives the per-output-position row select. Depends on kbt_pkg.
`timescale 1ns / 1ps

module kbt_rank
    import kbt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  key_t key,
    input  cnt_t row_len,
    input  logic dir,
    output sel_t sel
);

    sel_t rank_reg;
    sel_t rank_next;

    always_comb
    begin
        cnt_t acc;
        for (int j = 0; j < ROW_LIMIT; j++)
        begin
            acc = '0;
            for (int k = 0; k < ROW_LIMIT; k++)
            begin
                if ((CNT_W'(k) < row_len) &&
                    ((key[k] < key[j]) || ((key[k] == key[j]) && (k < j))))
                begin
                    acc = acc + cnt_t'(1);
                end
            end
            rank_next[j] = acc[IDX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < ROW_LIMIT; j++)
            begin
                rank_reg[j] <= idx_t'(j);
            end
        end
        else
        begin
            rank_reg <= rank_next;
        end
    end

    // Encrypt reads the inverse permutation, decrypt reads the ranks directly
    always_comb
    begin
        idx_t inv;
        for (int p = 0; p < ROW_LIMIT; p++)
        begin
            inv = '0;
            for (int j = 0; j < ROW_LIMIT; j++)
            begin
                if ((CNT_W'(j) < row_len) && (rank_reg[j] == idx_t'(p)))
                begin
                    inv = inv | idx_t'(j);
                end
            end
            sel[p] = (dir == DIR_DECRYPT) ? rank_reg[p] : inv;
        end
    end

endmodule

[rtl/kbt_fill.sv]
// Row fill stage: collects incoming bytes into the current row and hands a
// full, padded or dropped row to the emit buffer. Depends on kbt_pkg.
`timescale 1ns / 1ps

module kbt_fill
    import kbt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     in_ready,
    input  char_t    in_char,
    input  logic     in_last,
    input  cnt_t     row_len,
    input  logic     dir,
    output logic     needs_buf,
    output handoff_t ho
);

    row_t row_reg;
    cnt_t fill_reg;
    cnt_t fill_next;

    logic accept;
    cnt_t fill_eff;
    cnt_t fill_inc;
    logic full;
    row_t row_with;

    assign accept   = in_valid && in_ready;
    // Drop a stale partial row when the row length was lowered under it
    assign fill_eff = (fill_reg >= row_len) ? '0 : fill_reg;
    assign fill_inc = fill_eff + cnt_t'(1);
    assign full     = (fill_inc == row_len);
    // The offered byte closes a row and needs the emit buffer
    assign needs_buf = full || in_last;

    always_comb
    begin
        row_with = row_reg;
        row_with[fill_eff[IDX_W-1:0]] = in_char;
    end

    always_comb
    begin
        ho.valid = accept && needs_buf;
        ho.last  = in_last;
        ho.empty = !full && (dir == DIR_DECRYPT);
        ho.len   = ho.empty ? cnt_t'(1) : row_len;
        for (int j = 0; j < ROW_LIMIT; j++)
        begin
            ho.data[j] = (CNT_W'(j) < fill_inc) ? row_with[j] : PAD_CHAR;
        end
    end

    assign fill_next = ho.valid ? '0 : fill_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else if (accept)
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            row_reg <= row_with;
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < cnt_t'(ROW_LIMIT))
        else $error("fill count beyond row storage");

endmodule

[rtl/kbt_emit.sv]
// Emit buffer: holds one finished row and sends it out one item per cycle
// while out_ready is high, in permuted order. Depends on kbt_pkg.
`timescale 1ns / 1ps

module kbt_emit
    import kbt_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  handoff_t ho,
    input  sel_t     sel,
    output logic     free,
    output logic     out_valid,
    input  logic     out_ready,
    output char_t    out_char,
    output logic     out_last,
    output logic     out_empty
);

    logic busy_reg;
    idx_t idx_reg;
    cnt_t len_reg;
    logic last_reg;
    logic empty_reg;
    row_t buf_reg;

    logic beat_done;
    logic final_beat;

    assign beat_done  = busy_reg && out_ready;
    assign final_beat = ((cnt_t'(idx_reg) + cnt_t'(1)) == len_reg);
    assign free       = !busy_reg || (beat_done && final_beat);

    assign out_valid = busy_reg;
    assign out_char  = empty_reg ? '0 : buf_reg[sel[idx_reg]];
    assign out_last  = last_reg && final_beat;
    assign out_empty = empty_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (ho.valid)
        begin
            busy_reg <= 1'b1;
            idx_reg  <= '0;
        end
        else if (beat_done && final_beat)
        begin
            busy_reg <= 1'b0;
        end
        else if (beat_done)
        begin
            idx_reg <= idx_reg + idx_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ho.valid)
        begin
            buf_reg   <= ho.data;
            len_reg   <= ho.len;
            last_reg  <= ho.last;
            empty_reg <= ho.empty;
        end
    end

    a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        ho.valid |-> free)
        else $error("row handed over while buffer still holds items");

    a_idx_in_row: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> (cnt_t'(idx_reg) < len_reg))
        else $error("emit index past row length");

    a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && empty_reg) |-> (len_reg == cnt_t'(1)) && last_reg)
        else $error("end mark item not a single final item");

endmodule

[rtl/keyed_block_transposition.sv]
// Keyed block transposition, top level: configuration registers, row fill,
// key ranking and emit buffer. Depends on kbt_pkg, kbt_rank, kbt_fill, kbt_emit.
//
// Usage:
//   Input stream (s_*): one message byte per item, tlast on the final byte.
//   Output stream (m_*): permuted bytes, tlast on the final result of the
//   message, tuser set on the lone end-mark item of a dropped decrypt row.
//   Configuration (cfg_*): write key bytes, key length and direction while
//   the block is idle; cfg_ready is always high.
// Throughput: one byte per cycle in and out while m_tready stays high. A
//   row fills while the previous row drains from the emit buffer, so a
//   steady stream keeps both sides busy without gaps.
// Output: the first result of a row appears the cycle after the byte that
//   completes it; the row then drains at one item per cycle while m_tready is high.
// Stall: when the receiver holds m_tready low and the emit buffer is still
//   full, s_tready drops as soon as the next row would need the buffer.
// Reset: clears the row fill count, the emit buffer and the registers
//   (key 0, key length 1, encrypt). The block takes items right after reset.
`timescale 1ns / 1ps

module keyed_block_transposition
    import kbt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,    // [7:0] in_char
    input  logic                  s_tlast,    // in_last
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [7:0]            m_tdata,    // [7:0] out_char
    output logic                  m_tlast,    // out_last
    output logic                  m_tuser,    // [0] out_empty
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [63:0] key_low_reg;
    logic [15:0] key_high_reg;
    logic [3:0]  key_length_reg;
    logic        dir_reg;

    key_t     key;
    cnt_t     row_len;
    sel_t     sel;
    handoff_t ho;
    logic     free;
    logic     needs_buf;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_reg    <= '0;
            key_high_reg   <= '0;
            key_length_reg <= 4'd1;
            dir_reg        <= DIR_ENCRYPT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_KEY_LOW:    key_low_reg    <= cfg_data;
                REG_KEY_HIGH:   key_high_reg   <= cfg_data[15:0];
                REG_KEY_LENGTH: key_length_reg <= cfg_data[3:0];
                REG_DIRECTION:  dir_reg        <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    assign key = {key_high_reg, key_low_reg};

    // Clamp the key length into one to the row storage size
    always_comb
    begin
        if (key_length_reg == 4'd0)
        begin
            row_len = cnt_t'(1);
        end
        else if ({1'b0, key_length_reg} > 5'(ROW_LIMIT))
        begin
            row_len = cnt_t'(ROW_LIMIT);
        end
        else
        begin
            row_len = cnt_t'(key_length_reg);
        end
    end

    // Hold only the byte that would hand a row to a busy emit buffer
    assign s_tready = free || !needs_buf;

    kbt_rank u_rank (
        .clk     (clk),
        .rst_n   (rst_n),
        .key     (key),
        .row_len (row_len),
        .dir     (dir_reg),
        .sel     (sel)
    );

    kbt_fill u_fill (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_char   (s_tdata),
        .in_last   (s_tlast),
        .row_len   (row_len),
        .dir       (dir_reg),
        .needs_buf (needs_buf),
        .ho        (ho)
    );

    kbt_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .ho        (ho),
        .sel       (sel),
        .free      (free),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast),
        .out_empty (m_tuser)
    );

endmodule
